// ===== src/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

  // Built size of the queue and width of one stored tag
  localparam int DEPTH     = 16;
  localparam int TAG_WIDTH = 32;

  // Occupancy counter must hold DEPTH itself
  localparam int CNT_W   = $clog2(DEPTH + 1);
  // Fill limit register width is fixed by the register map
  localparam int LIMIT_W = 5;

  typedef logic [TAG_WIDTH-1:0] tag_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [LIMIT_W-1:0]   limit_t;

  // Requested operation
  typedef enum logic [1:0] {
    OP_PUSH_BACK = 2'd0,
    OP_POP_FRONT = 2'd1,
    OP_POP_BACK  = 2'd2,
    OP_REMOVE    = 2'd3
  } op_t;

  // Completion status of one transaction
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic valid;   // cell holds a live entry
    logic last;    // cell holds the back entry
    logic load;    // capture the incoming tag
    logic shift;   // take the neighbor's entry (front pop, whole row)
    logic remove;  // shift from the first match onward
  } cell_ctrl_t;

endpackage : bdq_pkg

`default_nettype wire

// ===== src/bounded_deque_with_remove.sv =====
`default_nettype none

// Bounded double-ended queue of tags built as a row of slot cells, front at
// cell 0. One operation per start pulse: push back, pop front, pop back, or
// remove the frontmost matching tag with the gap closed. Every transaction
// completes without a busy state: busy stays low, and the result appears with
// out_valid high for exactly one cycle, the cycle after start. The receiver
// cannot stall, so results must be captured on that cycle. A full push, an
// empty pop or a missed remove is refused with a status and leaves the queue
// unchanged. The compare of all slots and the first-match chain through the
// row set the clock-period path. cfg_ready is always high; write the fill
// limit only while no transaction is in flight.
module bounded_deque_with_remove (
  input  wire  logic                    clk,
  input  wire  logic                    rst_n,
  // command channel
  input  wire  logic                    start,
  output logic                          busy,
  input  wire  logic [1:0]              in_kind,
  input  wire  logic [31:0]             in_tag,
  // result channel
  output logic                          out_valid,
  output logic [31:0]                   out_tag,
  output logic [1:0]                    out_status,
  output logic [4:0]                    out_count,
  // configuration channel
  input  wire  logic                    cfg_valid,
  output logic                          cfg_ready,
  input  wire  logic [4:0]              cfg_fill_limit
);

  bdq_pkg::cnt_t   occ_r, occ_nxt;
  bdq_pkg::limit_t limit_r;
  logic            out_valid_r;
  bdq_pkg::tag_t   out_tag_r, out_tag_nxt;
  bdq_pkg::status_t out_status_r, out_status_nxt;
  bdq_pkg::cnt_t   out_count_r;

  bdq_pkg::op_t    op;
  logic            go;
  logic            push_ok;
  logic            found;
  bdq_pkg::tag_t   back_tag;

  bdq_pkg::cell_ctrl_t ctrl      [bdq_pkg::DEPTH];
  bdq_pkg::tag_t       cell_data [bdq_pkg::DEPTH];
  bdq_pkg::tag_t       cell_back [bdq_pkg::DEPTH];
  logic [bdq_pkg::DEPTH:0] found_chain;
  bdq_pkg::tag_t       next_data [bdq_pkg::DEPTH];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign go        = start && !busy;
  assign op        = bdq_pkg::op_t'(in_kind);

  // Limit above DEPTH acts as DEPTH
  assign push_ok = (32'(occ_r) < 32'(limit_r)) && (32'(occ_r) < bdq_pkg::DEPTH);

  // Row of slot cells
  assign found_chain[0] = 1'b0;
  for (genvar i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
    always_comb begin
      ctrl[i].valid  = (32'(i) < 32'(occ_r));
      ctrl[i].last   = (32'(i) + 32'd1 == 32'(occ_r));
      ctrl[i].load   = go && (op == bdq_pkg::OP_PUSH_BACK) && push_ok &&
                       (32'(i) == 32'(occ_r));
      ctrl[i].shift  = go && (op == bdq_pkg::OP_POP_FRONT);
      ctrl[i].remove = go && (op == bdq_pkg::OP_REMOVE);
    end

    if (i == bdq_pkg::DEPTH - 1) begin : g_tail
      assign next_data[i] = cell_data[i];
    end else begin : g_mid
      assign next_data[i] = cell_data[i+1];
    end

    bdq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .tag_in    (in_tag),
      .next_data (next_data[i]),
      .found_in  (found_chain[i]),
      .found_out (found_chain[i+1]),
      .data_out  (cell_data[i]),
      .back_data (cell_back[i])
    );
  end

  assign found = found_chain[bdq_pkg::DEPTH];

  // OR of the gated back-entry outputs
  always_comb begin
    back_tag = '0;
    for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
      back_tag = back_tag | cell_back[i];
    end
  end

  // Operation decode: status, popped tag, next occupancy
  always_comb begin
    occ_nxt        = occ_r;
    out_tag_nxt    = '0;
    out_status_nxt = bdq_pkg::ST_DONE;
    unique case (op)
      bdq_pkg::OP_PUSH_BACK: begin
        if (push_ok) begin
          occ_nxt = occ_r + 1'b1;
        end else begin
          out_status_nxt = bdq_pkg::ST_FULL;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (occ_r == '0) begin
          out_status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          out_tag_nxt = cell_data[0];
          occ_nxt     = occ_r - 1'b1;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (occ_r == '0) begin
          out_status_nxt = bdq_pkg::ST_EMPTY;
        end else begin
          out_tag_nxt = back_tag;
          occ_nxt     = occ_r - 1'b1;
        end
      end
      bdq_pkg::OP_REMOVE: begin
        if (found) begin
          occ_nxt = occ_r - 1'b1;
        end else begin
          out_status_nxt = bdq_pkg::ST_MISSING;
        end
      end
      default: begin
        out_status_nxt = bdq_pkg::ST_DONE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      limit_r     <= bdq_pkg::limit_t'(bdq_pkg::DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= go;
      if (go) begin
        occ_r <= occ_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_fill_limit;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (go) begin
      out_tag_r    <= out_tag_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= occ_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_tag    = out_tag_r;
  assign out_status = out_status_r;
  assign out_count  = 5'(out_count_r);

endmodule : bounded_deque_with_remove

`default_nettype wire

// ===== src/bdq_cell.sv =====
`default_nettype none

// One slot of the queue. Compares against the search tag, forwards the
// first-match flag to the next cell and shifts its neighbor's entry in.
module bdq_cell (
  input  wire logic              clk,
  input  wire bdq_pkg::cell_ctrl_t ctrl,
  input  wire bdq_pkg::tag_t     tag_in,
  input  wire bdq_pkg::tag_t     next_data,
  input  wire logic              found_in,
  output logic                   found_out,
  output bdq_pkg::tag_t          data_out,
  output bdq_pkg::tag_t          back_data
);

  bdq_pkg::tag_t data_r;
  bdq_pkg::tag_t data_nxt;
  logic          hit;

  // Match only counts on a live entry
  assign hit       = ctrl.valid && (data_r == tag_in);
  assign found_out = found_in || hit;

  // Slot update: load at the back, shift down at or after the gap
  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = tag_in;
    end else if (ctrl.shift || (ctrl.remove && found_out)) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out  = data_r;
  // AND-OR read of the back entry
  assign back_data = ctrl.last ? data_r : '0;

endmodule : bdq_cell

`default_nettype wire

// ===== src/bdq_chk.sv =====
`default_nettype none

// Port-level checks for the deque
module bdq_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_tag,
  input wire logic [1:0]  out_status,
  input wire logic [4:0]  out_count
);

  // Every accepted transaction gives a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transaction produced no result");

  // No result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without a transaction");

  // Refused operations return a zero tag
  a_zero_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bdq_pkg::ST_DONE) |-> (out_tag == '0))
    else $error("nonzero tag on refused operation");

  // Empty refusal means the queue is empty
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bdq_pkg::ST_EMPTY) |-> (out_count == '0))
    else $error("empty status with nonzero count");

  // Count never exceeds the built depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= bdq_pkg::DEPTH))
    else $error("count above depth");

endmodule : bdq_chk

bind bounded_deque_with_remove bdq_chk u_bdq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_tag    (out_tag),
  .out_status (out_status),
  .out_count  (out_count)
);

`default_nettype wire
